### hw/rtl/bgot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgot_pkg: blocked grid occupancy table package
// Field widths, register indexes, request codes and word types shared by the
// grid table and its testbench-facing ports.
// ----------------------------------------------------------------------------
package bgot_pkg;

  // fixed field widths
  localparam int POS_W      = 16;   // signed cell coordinate
  localparam int ID_W       = 16;   // item id as it travels on the ports
  localparam int OCC_W      = 7;    // reported block occupancy
  localparam int BW_W       = 7;    // block_width / block_height registers
  localparam int BA_W       = 9;    // blocks_across / blocks_down registers
  localparam int CFG_DATA_W = 9;    // widest register
  localparam int CFG_IDX_W  = 4;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_ACROSS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_DOWN   = CFG_IDX_W'(3);

  // register reset values
  localparam logic [BW_W-1:0] BLOCK_WIDTH_RST   = BW_W'(8);
  localparam logic [BW_W-1:0] BLOCK_HEIGHT_RST  = BW_W'(8);
  localparam logic [BA_W-1:0] BLOCKS_ACROSS_RST = BA_W'(16);
  localparam logic [BA_W-1:0] BLOCKS_DOWN_RST   = BA_W'(16);

  // request codes; the unused code behaves as a query
  localparam logic [1:0] REQ_PLACE  = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ID_W-1:0]         item_id;
  } req_t;

  typedef struct packed {
    logic             in_range;
    logic             was_occupied;
    logic [ID_W-1:0]  prior_item;
    logic [OCC_W-1:0] block_occupancy;
  } rsp_t;

endpackage
`default_nettype wire

### hw/rtl/blocked_grid_occupancy_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blocked_grid_occupancy_table: blocked grid cell store with block counts
// Places, removes and queries item ids in a 2D grid split into blocks, and
// reports the prior cell contents and the block count after each request.
// ----------------------------------------------------------------------------
//
//  channel | direction | word          | handshake
//  --------+-----------+---------------+----------------------------------
//  req     | in        | req_t         | req_valid / req_ready
//  rsp     | out       | rsp_t         | rsp_valid / rsp_ready
//  cfg     | in        | index + data  | cfg_we, no wait, no read-back
//
//  one request word is handled at a time: it is accepted in the idle state,
//  x and y are divided bit-serially by the block size, then it passes the
//  map, address, ram read and update states before the next word is taken
//  reset starts a clearing pass over all MAX_BLOCKS * MAX_BLOCK_CELLS
//  entries (16384 at the defaults) of the cell ram; req_ready stays low meanwhile
//  a result word waits in its output register; a new request is taken
//  while it waits, and the update cycle stalls only if it is still held
//
module blocked_grid_occupancy_table import bgot_pkg::*; #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MAX_BLOCK_CELLS = 64,
  parameter int ID_BITS         = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request words
  input  wire req_t                  req,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  // result words
  output rsp_t                       rsp,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  // register writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELL_DEPTH = MAX_BLOCKS * MAX_BLOCK_CELLS;
  localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int OFF_W      = (MAX_BLOCK_CELLS > 1) ? $clog2(MAX_BLOCK_CELLS) : 1;
  localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCK_CELLS + 1);
  localparam int CELL_W     = ID_BITS + 1;   // valid bit over item id

  // widths of the map products and sums
  localparam int PB_W = 2 * BA_W;            // quotient x blocks_down
  localparam int PO_W = 2 * BW_W;            // remainder x block_height

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DIV    = 7'b0000100,
    ST_MAP    = 7'b0001000,
    ST_ADDR   = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_UPDATE = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [BW_W-1:0] block_width, block_height;
  logic [BA_W-1:0] blocks_across, blocks_down;

  // request held for the whole item
  logic [1:0]         req_type;
  logic [ID_BITS-1:0] item_id;
  logic               x_neg, y_neg;

  // bit-serial dividers: quotient shifts in where the dividend shifts out
  logic [POS_W-1:0]     x_quo, y_quo;
  logic [BW_W-1:0]      x_rem, y_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [BW_W:0]        x_trial, y_trial;
  logic                 x_fit, y_fit;

  // map stage products and flags
  logic [PB_W-1:0] p_blk, p_blocks;
  logic [PO_W-1:0] p_off, p_cells;
  logic            qx_ok, qy_ok;

  // address stage results
  logic [PB_W:0]    blk_sum;
  logic [PO_W:0]    off_sum;
  logic             cfg_ok;
  logic [BLK_W-1:0] blk;
  logic [OFF_W-1:0] off;
  logic             ok;

  // clearing pass
  logic [CELL_AW-1:0] clr_addr;

  // ram ports
  logic [CELL_AW-1:0] cell_addr;
  logic               cell_we, cnt_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [BLK_W-1:0]   cnt_waddr;
  logic [CELL_W-1:0]  cell_wdata, cell_rdata;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;

  // update cycle
  logic               upd_fire;
  logic               was;
  logic [ID_BITS-1:0] prior_id;
  logic               is_place, is_remove;
  logic [CNT_W-1:0]   cnt_new;

  assign req_ready = (state == ST_IDLE);
  assign upd_fire  = (state == ST_UPDATE) && (!rsp_valid || rsp_ready);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      block_width   <= BLOCK_WIDTH_RST;
      block_height  <= BLOCK_HEIGHT_RST;
      blocks_across <= BLOCKS_ACROSS_RST;
      blocks_down   <= BLOCKS_DOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_WIDTH:   block_width   <= cfg_data[BW_W-1:0];
        CFG_BLOCK_HEIGHT:  block_height  <= cfg_data[BW_W-1:0];
        CFG_BLOCKS_ACROSS: blocks_across <= cfg_data[BA_W-1:0];
        CFG_BLOCKS_DOWN:   blocks_down   <= cfg_data[BA_W-1:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == CELL_AW'(CELL_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_DIV;
      ST_DIV:    if (div_cnt == DIV_CNT_W'(POS_W - 1)) state_next = ST_MAP;
      ST_MAP:    state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + CELL_AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- divide
  // restoring division, one quotient bit per cycle, x and y side by side
  assign x_trial = {x_rem, x_quo[POS_W-1]};
  assign y_trial = {y_rem, y_quo[POS_W-1]};
  assign x_fit   = (x_trial >= {1'b0, block_width});
  assign y_fit   = (y_trial >= {1'b0, block_height});

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req_type <= req.req_type;
      item_id  <= ID_BITS'(req.item_id);
      x_neg    <= req.pos_x[POS_W-1];
      y_neg    <= req.pos_y[POS_W-1];
      x_quo    <= req.pos_x;
      y_quo    <= req.pos_y;
      x_rem    <= '0;
      y_rem    <= '0;
      div_cnt  <= '0;
    end else if (state == ST_DIV) begin
      // remainder stays below the divisor, so it fits the register width
      x_rem   <= x_fit ? BW_W'(x_trial - {1'b0, block_width}) : x_trial[BW_W-1:0];
      y_rem   <= y_fit ? BW_W'(y_trial - {1'b0, block_height}) : y_trial[BW_W-1:0];
      x_quo   <= {x_quo[POS_W-2:0], x_fit};
      y_quo   <= {y_quo[POS_W-2:0], y_fit};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------- map
  // in-range along an axis is the same as quotient below the block count
  always_ff @(posedge clk) begin
    if (state == ST_MAP) begin
      p_blk    <= PB_W'(x_quo[BA_W-1:0]) * PB_W'(blocks_down);
      p_off    <= PO_W'(x_rem) * PO_W'(block_height);
      p_cells  <= PO_W'(block_width) * PO_W'(block_height);
      p_blocks <= PB_W'(blocks_across) * PB_W'(blocks_down);
      qx_ok    <= (x_quo < POS_W'(blocks_across));
      qy_ok    <= (y_quo < POS_W'(blocks_down));
    end
  end

  // ---------------------------------------------------------------- address
  assign blk_sum = {1'b0, p_blk} + (PB_W + 1)'(y_quo[BA_W-1:0]);
  assign off_sum = {1'b0, p_off} + (PO_W + 1)'(y_rem);

  // zero registers, oversized blocks or too many blocks make every request out of range
  assign cfg_ok = (block_width != '0) && (block_height != '0) &&
                  (blocks_across != '0) && (blocks_down != '0) &&
                  (32'(p_cells) <= 32'(MAX_BLOCK_CELLS)) &&
                  (32'(p_blocks) <= 32'(MAX_BLOCKS));

  always_ff @(posedge clk) begin
    if (state == ST_ADDR) begin
      blk <= BLK_W'(blk_sum);
      off <= OFF_W'(off_sum);
      ok  <= cfg_ok && !x_neg && !y_neg && qx_ok && qy_ok &&
             (32'(blk_sum) < 32'(MAX_BLOCKS)) &&
             (32'(off_sum) < 32'(MAX_BLOCK_CELLS));
    end
  end

  // cell entry = block * cells per block + offset
  assign cell_addr = CELL_AW'(32'(blk) * 32'(MAX_BLOCK_CELLS)) + CELL_AW'(off);

  // ---------------------------------------------------------------- update
  assign was       = cell_rdata[CELL_W-1];
  assign prior_id  = cell_rdata[ID_BITS-1:0];
  assign is_place  = (req_type == REQ_PLACE);
  assign is_remove = (req_type == REQ_REMOVE);

  // counts saturate at both ends in case the configuration moved
  always_comb begin
    cnt_new = cnt_rdata;
    if (is_place && !was && (32'(cnt_rdata) < 32'(MAX_BLOCK_CELLS))) begin
      cnt_new = cnt_rdata + CNT_W'(1);
    end else if (is_remove && was && (cnt_rdata != '0)) begin
      cnt_new = cnt_rdata - CNT_W'(1);
    end
  end

  // ram write ports: the clearing pass owns them after reset
  always_comb begin
    if (state == ST_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clr_addr;
      cell_wdata = '0;
      cnt_we     = (32'(clr_addr) < 32'(MAX_BLOCKS));
      cnt_waddr  = BLK_W'(clr_addr);
      cnt_wdata  = '0;
    end else begin
      cell_we    = upd_fire && ok && (is_place || (is_remove && was));
      cell_waddr = cell_addr;
      cell_wdata = is_place ? {1'b1, item_id} : {1'b0, prior_id};
      cnt_we     = upd_fire && ok && (is_place || is_remove);
      cnt_waddr  = blk;
      cnt_wdata  = cnt_new;
    end
  end

  bgot_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_addr),
    .rdata (cell_rdata)
  );

  bgot_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (blk),
    .rdata (cnt_rdata)
  );

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // out-of-range requests report all zero
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      rsp.in_range        <= ok;
      rsp.was_occupied    <= ok && was;
      rsp.prior_item      <= (ok && was) ? ID_W'(prior_id) : '0;
      rsp.block_occupancy <= ok ? OCC_W'(cnt_new) : '0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bgot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgot_ram: generic single write port, single read port ram
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bgot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/sv/tb_blocked_grid_occupancy_table.sv
// ----------------------------------------------------------------------------
// tb_blocked_grid_occupancy_table: self-checking bench for the grid table
// Sends place, remove and query words over a series of block layouts, keeps
// its own mirror of the cell store and the block counts, and compares every
// result word against the mirror's report for the matching request.
// ----------------------------------------------------------------------------
module tb_blocked_grid_occupancy_table import bgot_pkg::*; ();

  localparam int MAX_BLOCKS      = 256;
  localparam int MAX_BLOCK_CELLS = 64;
  localparam int ID_BITS         = 16;
  localparam int CELLS           = MAX_BLOCKS * MAX_BLOCK_CELLS;

  // the clearing pass plus about 430 words, taken roughly ten times over
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 50;
  localparam int NUM_PHASES  = 10;

  // the unused request code, handled as a query
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // an index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(9);

  // mirror of the cell store, the block counts and the layout registers
  class occupancy_mirror;
    bit              cell_valid [CELLS];
    logic [ID_W-1:0] cell_item [CELLS];
    int unsigned     block_count [MAX_BLOCKS];
    int unsigned     blk_w, blk_h, blks_across, blks_down;
    rsp_t            cell_reports [$];
    int              mismatches;

    function new();
      foreach (cell_valid[i]) cell_valid[i] = 1'b0;
      foreach (cell_item[i]) cell_item[i] = '0;
      foreach (block_count[i]) block_count[i] = 0;
      blk_w       = BLOCK_WIDTH_RST;
      blk_h       = BLOCK_HEIGHT_RST;
      blks_across = BLOCKS_ACROSS_RST;
      blks_down   = BLOCKS_DOWN_RST;
      mismatches  = 0;
    endfunction

    static function bit layout_ok(int unsigned bw, int unsigned bh,
                                  int unsigned ba, int unsigned bd);
      return bw != 0 && bh != 0 && ba != 0 && bd != 0 &&
             bw * bh <= MAX_BLOCK_CELLS && ba * bd <= MAX_BLOCKS;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx,
                                 logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLOCK_WIDTH:   blk_w = data[BW_W-1:0];
        CFG_BLOCK_HEIGHT:  blk_h = data[BW_W-1:0];
        CFG_BLOCKS_ACROSS: blks_across = data[BA_W-1:0];
        CFG_BLOCKS_DOWN:   blks_down = data[BA_W-1:0];
        default: ;
      endcase
    endfunction

    // apply one accepted request and queue the report it must produce
    function void apply_request(req_t r);
      rsp_t        rep;
      int unsigned x, y, blk, entry;
      bit          was;
      rep = '0;
      if (layout_ok(blk_w, blk_h, blks_across, blks_down) &&
          !r.pos_x[POS_W-1] && !r.pos_y[POS_W-1]) begin
        x = int'(r.pos_x);
        y = int'(r.pos_y);
        if (x < blk_w * blks_across && y < blk_h * blks_down) begin
          blk   = (x / blk_w) * blks_down + y / blk_h;
          entry = blk * MAX_BLOCK_CELLS + (x % blk_w) * blk_h + y % blk_h;
          was   = cell_valid[entry];
          rep.in_range     = 1'b1;
          rep.was_occupied = was;
          rep.prior_item   = was ? cell_item[entry] : '0;
          case (r.req_type)
            REQ_PLACE: begin
              if (!was && block_count[blk] < MAX_BLOCK_CELLS)
                block_count[blk]++;
              cell_valid[entry] = 1'b1;
              cell_item[entry]  = r.item_id;
            end
            REQ_REMOVE: begin
              if (was) begin
                cell_valid[entry] = 1'b0;
                if (block_count[blk] > 0)
                  block_count[blk]--;
              end
            end
            default: ;
          endcase
          rep.block_occupancy = OCC_W'(block_count[blk]);
        end
      end
      cell_reports.push_back(rep);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_report(rsp_t got);
      rsp_t want;
      if (cell_reports.size() == 0) begin
        $display("%0t: result word %0h with no request outstanding", $time, got);
        mismatches++;
      end else begin
        want = cell_reports.pop_front();
        check_field("in_range", want.in_range, got.in_range);
        check_field("was_occupied", want.was_occupied, got.was_occupied);
        check_field("prior_item", want.prior_item, got.prior_item);
        check_field("block_occupancy", want.block_occupancy, got.block_occupancy);
      end
    endfunction

    function int pending();
      return cell_reports.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  req_t                  req;
  logic                  req_valid;
  logic                  req_ready;
  rsp_t                  rsp;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  occupancy_mirror mirror;
  bit              idle_off = 1'b0;   // no gaps or stalls while set
  int              stall_left = 0;
  int              cycles = 0;

  // layout of the current phase, used to aim coordinates
  int g_width, g_height;
  int hot_x0, hot_y0, hot_w, hot_h;

  blocked_grid_occupancy_table #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_CELLS (MAX_BLOCK_CELLS),
    .ID_BITS         (ID_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** blocked_grid_occupancy_table: FAILED **");
      $finish;
    end
  end

  // result side: ready high except for random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= (stall_left == 1);
    end else if (!idle_off && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 11);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // handshakes are seen with the values from just before the edge, since
  // every driver here and in the block updates by nonblocking assignment
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we)
        mirror.write_register(cfg_index, cfg_data);
      if (req_valid && req_ready)
        mirror.apply_request(req);
      if (rsp_valid && rsp_ready)
        mirror.compare_report(rsp);
    end
  end

  // hold one request word until it is taken, sometimes after an idle burst
  task automatic send_request(input req_t w);
    if (!idle_off && $urandom_range(0, 2) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_at(input logic [1:0] kind, input int x, input int y,
                         input logic [ID_W-1:0] id);
    req_t w;
    w.req_type = kind;
    w.pos_x    = POS_W'(x);
    w.pos_y    = POS_W'(y);
    w.item_id  = id;
    send_request(w);
  endtask

  // stop sending until every outstanding result word is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    // let the word taken at the last edge reach the mirror first
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // aim the hot window at one block, often the last one of the grid
  task automatic set_geometry(input int unsigned bw, input int unsigned bh,
                              input int unsigned ba, input int unsigned bd);
    int bx, by;
    if (occupancy_mirror::layout_ok(bw, bh, ba, bd)) begin
      g_width  = bw * ba;
      g_height = bh * bd;
      hot_w    = (bw < 4) ? bw : 4;
      hot_h    = (bh < 4) ? bh : 4;
      bx = $urandom_range(0, 1) ? ba - 1 : $urandom_range(0, ba - 1);
      by = $urandom_range(0, 1) ? bd - 1 : $urandom_range(0, bd - 1);
      hot_x0 = bx * bw + $urandom_range(0, bw - hot_w);
      hot_y0 = by * bh + $urandom_range(0, bh - hot_h);
    end else begin
      g_width  = 64;
      g_height = 64;
      hot_w    = 4;
      hot_h    = 4;
      hot_x0   = 0;
      hot_y0   = 0;
    end
  endtask

  // the narrow registers get junk in the upper data bits, which must be
  // dropped; a write to an index with no register must change nothing
  task automatic set_config(input int unsigned bw, input int unsigned bh,
                            input int unsigned ba, input int unsigned bd);
    write_reg(CFG_BLOCK_WIDTH, {2'($urandom_range(0, 3)), BW_W'(bw)});
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_BLOCK_HEIGHT, {2'($urandom_range(0, 3)), BW_W'(bh)});
    write_reg(CFG_BLOCKS_ACROSS, BA_W'(ba));
    write_reg(CFG_BLOCKS_DOWN, BA_W'(bd));
    cfg_we <= 1'b0;
    set_geometry(bw, bh, ba, bd);
  endtask

  // layouts: reset values, the two extreme shapes, a single cell, one
  // unusable layout, and random usable ones leaning to small blocks
  task automatic pick_layout(input int ph, output int unsigned bw,
                             output int unsigned bh, output int unsigned ba,
                             output int unsigned bd);
    case (ph)
      0: begin bw = 8;  bh = 8;  ba = 16; bd = 16;  end
      1: begin bw = 64; bh = 1;  ba = 1;  bd = 256; end
      2: begin bw = 1;  bh = 64; ba = 256; bd = 1;  end
      3: begin bw = 1;  bh = 1;  ba = 1;  bd = 1;   end
      4: begin
        bw = 8; bh = 8; ba = 16; bd = 16;
        case ($urandom_range(0, 5))
          0: bw = 0;
          1: bh = 0;
          2: ba = 0;
          3: bd = 0;
          4: begin bw = $urandom_range(9, 64); bh = $urandom_range(8, 64); end
          default: begin ba = $urandom_range(17, 256); bd = $urandom_range(16, 256); end
        endcase
      end
      default: begin
        bw = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 64);
        bh = $urandom_range(1, MAX_BLOCK_CELLS / bw);
        ba = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 256);
        bd = $urandom_range(1, MAX_BLOCKS / ba);
      end
    endcase
  endtask

  // mostly requests inside the hot window so cells get reused, plus the
  // whole grid, the edges just outside it, negatives and raw 16-bit values
  function automatic req_t make_request();
    req_t w;
    int   kind, xv, yv, t;
    kind = $urandom_range(0, 9);
    xv = hot_x0 + $urandom_range(0, hot_w - 1);
    yv = hot_y0 + $urandom_range(0, hot_h - 1);
    case (kind)
      0: begin
        xv = $urandom_range(0, 65535);
        yv = $urandom_range(0, 65535);
      end
      1: begin
        if ($urandom_range(0, 1)) xv = g_width;
        else yv = g_height;
      end
      2: begin
        if ($urandom_range(0, 1)) xv = 0 - int'($urandom_range(1, 3));
        else yv = 0 - int'($urandom_range(1, 3));
      end
      3: begin
        xv = $urandom_range(0, g_width - 1);
        yv = $urandom_range(0, g_height - 1);
      end
      default: ;
    endcase
    t = $urandom_range(0, 19);
    w.req_type = (t < 9) ? REQ_PLACE : (t < 14) ? REQ_REMOVE :
                 (t < 18) ? REQ_QUERY : REQ_SPARE;
    w.pos_x   = POS_W'(xv);
    w.pos_y   = POS_W'(yv);
    w.item_id = ID_W'($urandom);
    return w;
  endfunction

  initial begin
    int unsigned bw, bh, ba, bd;
    int          items;
    mirror    = new();
    rst       = 1'b1;
    req       = '0;
    req_valid = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    set_geometry(BLOCK_WIDTH_RST, BLOCK_HEIGHT_RST, BLOCKS_ACROSS_RST,
                 BLOCKS_DOWN_RST);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words on the reset layout (128 x 128 cells); the first one
    // also waits out the clearing pass
    send_at(REQ_PLACE, 0, 0, 16'hFFFF);
    send_at(REQ_QUERY, 0, 0, 16'h0000);
    send_at(REQ_PLACE, 0, 0, 16'h0000);     // overwrite, count unchanged
    send_at(REQ_SPARE, 0, 0, 16'h5A5A);     // unused code reads like a query
    send_at(REQ_REMOVE, 0, 0, 16'hFFFF);
    send_at(REQ_REMOVE, 0, 0, 16'h0000);    // remove of an empty cell
    send_at(REQ_QUERY, 0, 0, 16'h0000);
    send_at(REQ_PLACE, 127, 127, 16'h8001);
    send_at(REQ_PLACE, 127, 120, 16'h7FFE); // same block, count two
    send_at(REQ_PLACE, -1, 0, 16'h1111);    // negative x
    send_at(REQ_REMOVE, 0, -1, 16'h0000);   // negative y
    send_at(REQ_QUERY, 128, 5, 16'h0000);   // just past the right edge
    send_at(REQ_QUERY, 5, 128, 16'h0000);   // just past the bottom edge
    send_at(REQ_PLACE, 32767, 32767, 16'hAAAA);
    send_at(REQ_PLACE, -32768, -32768, 16'h5555);
    wait_drained();

    // single-cell grid
    set_config(1, 1, 1, 1);
    send_at(REQ_PLACE, 0, 0, 16'h1234);
    send_at(REQ_PLACE, 1, 0, 16'h4321);
    send_at(REQ_QUERY, 0, 1, 16'h0000);
    wait_drained();

    // unusable layouts: a zero register, too many cells per block, too many
    // blocks; every word reads as out of range
    set_config(0, 8, 16, 16);
    send_at(REQ_PLACE, 0, 0, 16'hBEEF);
    wait_drained();
    set_config(64, 64, 1, 1);
    send_at(REQ_QUERY, 0, 0, 16'h0000);
    wait_drained();
    set_config(1, 1, 256, 256);
    send_at(REQ_QUERY, 0, 0, 16'h0000);
    wait_drained();

    // random phases, each on its own layout; the last runs with no idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick_layout(ph, bw, bh, ba, bd);
      set_config(bw, bh, ba, bd);
      idle_off = (ph == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
      items = (ph == 4) ? 12 : 43;
      for (int n = 0; n < items; n++) begin
        // some phases pause halfway until the table has answered everything
        if (n == items / 2 && ph % 3 == 1)
          wait_drained();
        send_request(make_request());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("** blocked_grid_occupancy_table: PASSED **");
    end else begin
      $display("** blocked_grid_occupancy_table: FAILED **");
    end
    $finish;
  end

endmodule
